// ===== rtl/core/ttpl_pkg.sv =====
// Shared types, widths and tables for the tetrahedral tree point locator.
`default_nettype none
package ttpl_pkg;

   localparam int COORD_W   = 32;
   localparam int DIFF_W    = 34;
   localparam int CROSS_W   = 68;
   localparam int ACC_W     = 104;
   localparam int CHUNK_W   = 17;
   localparam int PP_W      = CHUNK_W + 1 + DIFF_W;
   localparam int ELEM_W    = 16;
   localparam int SIZE_W    = 16;
   localparam int TREE_W    = 8;
   localparam int CORNER_W  = 2;
   localparam int LEVEL_W   = 5;
   localparam int MAX_DEPTH = 16;
   localparam int CMEM_W    = 3 * COORD_W;

   typedef enum logic [1:0] {
      MODE_SIZE   = 2'd0,
      MODE_CORNER = 2'd1,
      MODE_LOCATE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      DET_ROOT = 2'd0,
      DET_U    = 2'd1,
      DET_V    = 2'd2,
      DET_W    = 2'd3
   } det_sel_type;

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_CORNER = 16'h0002,
      S_DIFF   = 16'h0004,
      S_MAC    = 16'h0008,
      S_DRAIN  = 16'h0010,
      S_HALF   = 16'h0020,
      S_CHECK  = 16'h0040,
      S_TEST   = 16'h0080,
      S_CMP0   = 16'h0100,
      S_CMP1   = 16'h0200,
      S_CMP2   = 16'h0400,
      S_NEWCOR = 16'h0800,
      S_SUMRD  = 16'h1000,
      S_SUMACC = 16'h2000,
      S_STEP   = 16'h4000,
      S_DONE   = 16'h8000
   } state_type;

   // per child, corner i in bits [4i+3:4i] as {a, b}: new corner = midpoint(a, b)
   localparam logic [15:0] CHILD_PAIRS [8] = '{
      16'h3210, 16'h1237, 16'h6745, 16'h4768,
      16'h98BA, 16'hB89D, 16'hCDEF, 16'hEDC8
   };

endpackage
`default_nettype wire

// ===== rtl/core/tet_tree_point_locate.sv =====
// Top level: point location in a refinement tree of tetrahedra.
//
// Input channel (req_*): an item is taken when start is high and busy low.
//   mode 0 writes a subtree size, mode 1 writes a root corner; both finish
//   in the accept cycle and busy stays low. Mode 3 is dropped. Mode 2
//   locates the query point and raises busy until its result is out.
// Result channel (rsp_*): rsp_strobe is high for one cycle with the found
//   element and the number of levels descended. The receiver cannot stall.
// A locate item loads the root corners and forms the root volume, then
//   per level runs the leaf test, three determinants, three compare
//   steps, the new corners, the sibling sum and the step down, then a final
//   leaf test and the result strobe. Each determinant runs on one 18x34
//   multiplier feeding a 104-bit accumulator: a difference step, six 2-chunk
//   cross terms, three 4-chunk dot terms and a drain step. Sibling summing
//   alternates a read and an accumulate step per sibling, set by the
//   registered read of the size table; one item is in flight at a time.
// Reset clears the sequencer and the strobe. Both tables are left as they
//   are and must be written before they are used.
`default_nettype none
module tet_tree_point_locate
   import ttpl_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire  [1:0]                 req_mode,
   input  wire  [ELEM_W-1:0]          req_element_index,
   input  wire  [SIZE_W-1:0]          req_subtree_size,
   input  wire  [TREE_W-1:0]          req_tree_index,
   input  wire  [CORNER_W-1:0]        req_corner,
   input  wire  signed [COORD_W-1:0]  req_coord_x,
   input  wire  signed [COORD_W-1:0]  req_coord_y,
   input  wire  signed [COORD_W-1:0]  req_coord_z,
   input  wire  [ELEM_W-1:0]          req_root_element,
   input  wire  [LEVEL_W-1:0]         req_level_limit,
   output logic                       rsp_strobe,
   output logic [ELEM_W-1:0]          rsp_found_element,
   output logic [LEVEL_W-1:0]         rsp_level_reached
);

   state_type state_ff, state_in;
   det_sel_type det_sel_ff;

   logic [SIZE_W-1:0] size_mem [2**ELEM_W];
   logic [CMEM_W-1:0] corner_mem [2**(TREE_W+CORNER_W)];
   logic [SIZE_W-1:0] size_rd_ff;
   logic [CMEM_W-1:0] corner_rd_ff;
   logic [ELEM_W-1:0] size_raddr;

   logic signed [COORD_W-1:0] cor_ff [4][3];
   logic signed [COORD_W-1:0] pt_ff [3];
   logic signed [COORD_W-1:0] nc [4][3];
   logic signed [COORD_W-1:0] pa [3];
   logic signed [COORD_W-1:0] pb [3];
   logic signed [COORD_W-1:0] pc [3];
   logic signed [DIFF_W-1:0]  pd_ff [3];
   logic signed [DIFF_W-1:0]  qd_ff [3];
   logic signed [DIFF_W-1:0]  sd_ff [3];
   logic signed [CROSS_W-1:0] cx_ff, cy_ff, cz_ff;

   logic [TREE_W-1:0]  tree_ff;
   logic [ELEM_W-1:0]  id_ff, off_ff;
   logic [LEVEL_W-1:0] level_ff, limit_ff;
   logic [2:0]         cnt_ff, sib_ff, child_ff, child;
   logic [3:0]         k_ff;
   logic [1:0]         ch_ff, ch_last;

   logic signed [CROSS_W-1:0] xfull;
   logic [CHUNK_W-1:0]        xchunk;
   logic signed [CHUNK_W:0]   xs;
   logic signed [DIFF_W-1:0]  ys;
   logic signed [PP_W-1:0]    pp_in, pp_ff;
   logic                      pp_v_ff, pp_first_ff, pp_last_ff, pp_neg_ff;
   logic [1:0]                pp_ch_ff, pp_grp_ff;
   logic                      is_first, is_last, is_neg, x_top;
   logic [1:0]                grp;

   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_base, pp_ext, pp_shl;
   logic signed [ACC_W-1:0] u_ff, v_ff, w_ff, hf_ff, hc_ff, t_ff;
   logic                    rx_ff, ry_ff, rz_ff, lt_ff;

   logic take;
   assign take = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);
   assign rsp_found_element = id_ff;
   assign rsp_level_reached = level_ff;

   // tables
   assign size_raddr = (state_ff == S_CHECK) ? id_ff : id_ff + off_ff;

   always_ff @(posedge clock) begin
      if (take && req_mode == MODE_SIZE) begin
         size_mem[req_element_index] <= req_subtree_size;
      end
      size_rd_ff <= size_mem[size_raddr];
   end

   always_ff @(posedge clock) begin
      if (take && req_mode == MODE_CORNER) begin
         corner_mem[{req_tree_index, req_corner}] <= {req_coord_x, req_coord_y, req_coord_z};
      end
      corner_rd_ff <= corner_mem[{tree_ff, cnt_ff[1:0]}];
   end

   // determinant operand points
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         unique case (det_sel_ff)
            DET_ROOT: begin pa[j] = cor_ff[0][j]; pb[j] = cor_ff[2][j]; pc[j] = cor_ff[1][j]; end
            DET_U:    begin pa[j] = cor_ff[1][j]; pb[j] = pt_ff[j];     pc[j] = cor_ff[2][j]; end
            DET_V:    begin pa[j] = pt_ff[j];     pb[j] = cor_ff[0][j]; pc[j] = cor_ff[2][j]; end
            DET_W:    begin pa[j] = cor_ff[1][j]; pb[j] = cor_ff[0][j]; pc[j] = pt_ff[j];     end
            default:  begin pa[j] = cor_ff[0][j]; pb[j] = cor_ff[0][j]; pc[j] = cor_ff[0][j]; end
         endcase
      end
   end

   // multiplier issue
   always_comb begin
      unique case (k_ff)
         4'd0:    begin xfull = CROSS_W'(pd_ff[1]); ys = qd_ff[2]; end
         4'd1:    begin xfull = CROSS_W'(pd_ff[2]); ys = qd_ff[1]; end
         4'd2:    begin xfull = CROSS_W'(pd_ff[2]); ys = qd_ff[0]; end
         4'd3:    begin xfull = CROSS_W'(pd_ff[0]); ys = qd_ff[2]; end
         4'd4:    begin xfull = CROSS_W'(pd_ff[0]); ys = qd_ff[1]; end
         4'd5:    begin xfull = CROSS_W'(pd_ff[1]); ys = qd_ff[0]; end
         4'd6:    begin xfull = cx_ff;              ys = sd_ff[0]; end
         4'd7:    begin xfull = cy_ff;              ys = sd_ff[1]; end
         default: begin xfull = cz_ff;              ys = sd_ff[2]; end
      endcase
      unique case (ch_ff)
         2'd0:    xchunk = xfull[CHUNK_W-1:0];
         2'd1:    xchunk = xfull[2*CHUNK_W-1:CHUNK_W];
         2'd2:    xchunk = xfull[3*CHUNK_W-1:2*CHUNK_W];
         default: xchunk = xfull[4*CHUNK_W-1:3*CHUNK_W];
      endcase
      ch_last  = (k_ff < 4'd6) ? 2'd1 : 2'd3;
      x_top    = (ch_ff == ch_last);
      xs       = x_top ? {xchunk[CHUNK_W-1], xchunk} : {1'b0, xchunk};
      pp_in    = xs * ys;
      is_first = (ch_ff == 2'd0) &&
                 (k_ff == 4'd0 || k_ff == 4'd2 || k_ff == 4'd4 || k_ff == 4'd6);
      is_last  = x_top && (k_ff == 4'd1 || k_ff == 4'd3 || k_ff == 4'd5 || k_ff == 4'd8);
      is_neg   = (k_ff == 4'd1 || k_ff == 4'd3 || k_ff == 4'd5);
      grp      = (k_ff < 4'd2) ? 2'd0 : (k_ff < 4'd4) ? 2'd1 : (k_ff < 4'd6) ? 2'd2 : 2'd3;
   end

   // accumulate stage
   always_comb begin
      pp_ext = ACC_W'(pp_ff);
      unique case (pp_ch_ff)
         2'd0:    pp_shl = pp_ext;
         2'd1:    pp_shl = pp_ext <<< CHUNK_W;
         2'd2:    pp_shl = pp_ext <<< (2 * CHUNK_W);
         default: pp_shl = pp_ext <<< (3 * CHUNK_W);
      endcase
      acc_base = pp_first_ff ? '0 : acc_ff;
      acc_in   = pp_neg_ff ? acc_base - pp_shl : acc_base + pp_shl;
   end

   // child selection and new corners
   always_comb begin
      logic [15:0] pair;
      logic [1:0]  ai, bi;
      logic signed [COORD_W:0] s;
      child = {rx_ff, rx_ff == ry_ff, rz_ff};
      pair  = CHILD_PAIRS[child];
      for (int i = 0; i < 4; i++) begin
         ai = pair[4*i+2 +: 2];
         bi = pair[4*i +: 2];
         for (int j = 0; j < 3; j++) begin
            s = (COORD_W+1)'(cor_ff[ai][j]) + (COORD_W+1)'(cor_ff[bi][j]);
            nc[i][j] = s[COORD_W:1];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (take && req_mode == MODE_LOCATE) state_in = S_CORNER;
         S_CORNER: if (cnt_ff == 3'd4) state_in = S_DIFF;
         S_DIFF:   state_in = S_MAC;
         S_MAC:    if (k_ff == 4'd8 && x_top) state_in = S_DRAIN;
         S_DRAIN: begin
            unique case (det_sel_ff)
               DET_ROOT: state_in = S_HALF;
               DET_W:    state_in = S_CMP0;
               default:  state_in = S_DIFF;
            endcase
         end
         S_HALF:   state_in = S_CHECK;
         S_CHECK:  state_in = S_TEST;
         S_TEST: begin
            if (size_rd_ff == '0 || level_ff == limit_ff) state_in = S_DONE;
            else state_in = S_DIFF;
         end
         S_CMP0:   state_in = S_CMP1;
         S_CMP1:   state_in = S_CMP2;
         S_CMP2:   state_in = S_NEWCOR;
         S_NEWCOR: state_in = (child == 3'd0) ? S_STEP : S_SUMRD;
         S_SUMRD:  state_in = S_SUMACC;
         S_SUMACC: state_in = (sib_ff + 3'd1 == child_ff) ? S_STEP : S_SUMRD;
         S_STEP:   state_in = S_CHECK;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pp_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pp_v_ff  <= (state_ff == S_MAC);
      end
   end

   always_ff @(posedge clock) begin
      pp_ff       <= pp_in;
      pp_ch_ff    <= ch_ff;
      pp_first_ff <= is_first;
      pp_last_ff  <= is_last;
      pp_neg_ff   <= is_neg;
      pp_grp_ff   <= grp;
      if (pp_v_ff) begin
         acc_ff <= acc_in;
         if (pp_last_ff) begin
            unique case (pp_grp_ff)
               2'd0: cx_ff <= acc_in[CROSS_W-1:0];
               2'd1: cy_ff <= acc_in[CROSS_W-1:0];
               2'd2: cz_ff <= acc_in[CROSS_W-1:0];
               default: begin
                  unique case (det_sel_ff)
                     DET_V:   v_ff <= acc_in;
                     DET_W:   w_ff <= acc_in;
                     default: u_ff <= acc_in;
                  endcase
               end
            endcase
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            tree_ff    <= req_tree_index;
            id_ff      <= req_root_element;
            limit_ff   <= (req_level_limit > LEVEL_W'(MAX_DEPTH)) ?
                          LEVEL_W'(MAX_DEPTH) : req_level_limit;
            pt_ff[0]   <= req_coord_x;
            pt_ff[1]   <= req_coord_y;
            pt_ff[2]   <= req_coord_z;
            level_ff   <= '0;
            cnt_ff     <= '0;
            det_sel_ff <= DET_ROOT;
         end
         S_CORNER: begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff != 3'd0) begin
               cor_ff[cnt_ff[1:0] - 2'd1][0] <= corner_rd_ff[3*COORD_W-1:2*COORD_W];
               cor_ff[cnt_ff[1:0] - 2'd1][1] <= corner_rd_ff[2*COORD_W-1:COORD_W];
               cor_ff[cnt_ff[1:0] - 2'd1][2] <= corner_rd_ff[COORD_W-1:0];
            end
         end
         S_DIFF: begin
            for (int j = 0; j < 3; j++) begin
               pd_ff[j] <= DIFF_W'(pb[j]) - DIFF_W'(pa[j]);
               qd_ff[j] <= DIFF_W'(pc[j]) - DIFF_W'(pa[j]);
               sd_ff[j] <= DIFF_W'(cor_ff[3][j]) - DIFF_W'(pa[j]);
            end
            k_ff  <= '0;
            ch_ff <= '0;
         end
         S_MAC: begin
            if (x_top) begin
               ch_ff <= '0;
               k_ff  <= k_ff + 4'd1;
            end else begin
               ch_ff <= ch_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            unique case (det_sel_ff)
               DET_U:   det_sel_ff <= DET_V;
               DET_V:   det_sel_ff <= DET_W;
               default: det_sel_ff <= det_sel_ff;
            endcase
         end
         S_HALF: begin
            hf_ff <= u_ff >>> 1;
            hc_ff <= (u_ff + ACC_W'(1)) >>> 1;
         end
         S_TEST:  det_sel_ff <= DET_U;
         S_CMP0: begin
            t_ff  <= u_ff + v_ff;
            rx_ff <= (u_ff + v_ff) < hc_ff;
         end
         S_CMP1: begin
            ry_ff <= (v_ff + w_ff) < hc_ff;
            lt_ff <= (u_ff < hc_ff) && (v_ff < hc_ff) && (w_ff < hc_ff);
         end
         S_CMP2:  rz_ff <= lt_ff && (hf_ff < t_ff + w_ff);
         S_NEWCOR: begin
            for (int i = 0; i < 4; i++) begin
               for (int j = 0; j < 3; j++) cor_ff[i][j] <= nc[i][j];
            end
            child_ff <= child;
            off_ff   <= ELEM_W'(1);
            sib_ff   <= '0;
         end
         S_SUMACC: begin
            off_ff <= off_ff + size_rd_ff + ELEM_W'(1);
            sib_ff <= sib_ff + 3'd1;
         end
         S_STEP: begin
            id_ff    <= id_ff + off_ff;
            level_ff <= level_ff + LEVEL_W'(1);
            hf_ff    <= hf_ff >>> 3;
            hc_ff    <= (hc_ff + ACC_W'(7)) >>> 3;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire
